/* hdl/c8_pkg.sv */
package c8_pkg;

  localparam int MEM_BYTES    = 4096;
  localparam int MEM_AW       = 12;
  localparam int DISP_W       = 64;
  localparam int DISP_H       = 32;
  localparam int DISP_RW      = 5;
  localparam int STACK_DEPTH  = 16;
  localparam logic [11:0] START_RESET = 12'd512;

  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_STEP  = 3'd2;
  localparam logic [2:0] OP_KDN   = 3'd3;
  localparam logic [2:0] OP_KUP   = 3'd4;
  localparam logic [2:0] OP_TICK  = 3'd5;
  localparam logic [2:0] OP_DISP  = 3'd6;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_WAIT = 3'd1;
  localparam logic [2:0] ST_NIMP = 3'd2;
  localparam logic [2:0] ST_OVF  = 3'd3;
  localparam logic [2:0] ST_UNF  = 3'd4;
  localparam logic [2:0] ST_HALT = 3'd5;

  localparam logic [15:0] OPW_CLS = 16'h00E0;
  localparam logic [15:0] OPW_RET = 16'h00EE;
  localparam logic [7:0] KK_SKP  = 8'h9E;
  localparam logic [7:0] KK_SKNP = 8'hA1;
  localparam logic [7:0] KK_GDT  = 8'h07;
  localparam logic [7:0] KK_WKEY = 8'h0A;
  localparam logic [7:0] KK_SDT  = 8'h15;
  localparam logic [7:0] KK_SST  = 8'h18;
  localparam logic [7:0] KK_FONT = 8'h29;
  localparam logic [7:0] KK_BCD  = 8'h33;
  localparam logic [7:0] KK_DUMP = 8'h55;
  localparam logic [7:0] KK_LOAD = 8'h65;
  localparam logic [7:0] KK_ADDI = 8'h1E;

  localparam logic [3:0] REG_VF = 4'hF;

  typedef struct packed {
    logic [2:0]  operation;
    logic [11:0] address;
    logic [7:0]  data;
    logic [3:0]  key;
    logic [7:0]  random_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] pc;
    logic [7:0]  read_data;
    logic [15:0] executed_opcode;
  } out_item_t;

endpackage

/* hdl/c8_ram.sv */
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/chip8_instruction_core_unit.sv */
// CHIP-8 instruction core. Each transfer on the input channel carries one
// operation and yields exactly one result transfer. A step fetches the two
// opcode bytes and reads two registers through the single read port of each
// memory; Dxyn reads and writes each drawn sprite row in turn, Fx55 and Fx65
// handle one register at a time, and Fx33 writes its three digits one by one.
// A new item is taken once the previous one has placed its result in the
// output register. Main memory and the return stack come up with unknown
// contents; registers and the framebuffer read as zero after reset through
// valid bits.
module chip8_instruction_core_unit #(
  parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  c8_pkg::in_item_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output c8_pkg::out_item_t out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import c8_pkg::*;

  localparam int SIW = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_DISP    = 18'h00002,
    S_MRD     = 18'h00004,
    S_FRD     = 18'h00008,
    S_F1      = 18'h00010,
    S_F2      = 18'h00020,
    S_RY      = 18'h00040,
    S_EX      = 18'h00080,
    S_WF      = 18'h00100,
    S_RET     = 18'h00200,
    S_DRAW_RD = 18'h00400,
    S_DRAW_WR = 18'h00800,
    S_BCD     = 18'h01000,
    S_DUMP_RD = 18'h02000,
    S_DUMP_WR = 18'h04000,
    S_LOAD_RD = 18'h08000,
    S_LOAD_WR = 18'h10000,
    S_DONE    = 18'h20000
  } state_t;

  state_t         state;
  in_item_t       it;
  logic [11:0]    pc, start_addr, ireg;
  logic [SCW-1:0] sc;
  logic [7:0]     dt;
  logic [15:0]    keys;
  logic           waiting, halted;
  logic [3:0]     wtarget;
  logic [2:0]     status_q;
  logic [7:0]     rd_q, hi_q, vx_q;
  logic [15:0]    op_q;
  logic           flag_q, hit_q, rv_q, fv_q;
  logic [3:0]     cnt;
  logic [5:0]     x0_q;
  logic [4:0]     y0_q;
  logic [15:0]    reg_valid;
  logic [31:0]    fb_valid;

  // memory ports
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic              reg_we;
  logic [3:0]        reg_waddr, reg_raddr;
  logic [7:0]        reg_wdata, reg_rdata;
  logic              fb_we;
  logic [DISP_RW-1:0] fb_waddr, fb_raddr;
  logic [DISP_W-1:0] fb_wdata, fb_rdata;
  logic              stk_we;
  logic [SIW-1:0]    stk_waddr, stk_raddr;
  logic [11:0]       stk_wdata, stk_rdata;

  c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata));
  c8_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
    .clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
    .raddr(reg_raddr), .rdata(reg_rdata));
  c8_ram #(.WIDTH(DISP_W), .DEPTH(DISP_H)) u_fb (
    .clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
    .raddr(fb_raddr), .rdata(fb_rdata));
  c8_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata));

  // derived values
  logic [7:0]  rval, kk, vy;
  logic [3:0]  nib;
  logic [11:0] nnn, pc2, pc4;
  logic [DISP_W-1:0] fbval, sprite_mask, disp_shift;
  logic [5:0]  draw_row;
  logic        key_hit;
  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [3:0]  tens, ones;
  logic [7:0]  digit;
  logic        kdn_store;

  assign rval  = rv_q ? reg_rdata : 8'd0;
  assign vy    = rval;
  assign fbval = fv_q ? fb_rdata : '0;
  assign kk    = op_q[7:0];
  assign nib   = op_q[15:12];
  assign nnn   = op_q[11:0];
  assign pc2   = pc + 12'd2;
  assign pc4   = pc + 12'd4;
  assign draw_row    = {1'b0, y0_q} + {2'b00, cnt};
  assign sprite_mask = {mem_rdata, {(DISP_W-8){1'b0}}} >> x0_q;
  assign disp_shift  = fbval << {it.address[2:0], 3'b000};
  assign key_hit     = keys[vx_q[3:0]];
  assign kdn_store   = (it.operation == OP_KDN) && waiting && !halted;

  // Decimal digits without a divider: hundreds by compare, tens by reciprocal.
  always_comb begin
    if (vx_q >= 8'd200) begin
      hund = 2'd2;
    end else if (vx_q >= 8'd100) begin
      hund = 2'd1;
    end else begin
      hund = 2'd0;
    end
    rem       = 7'(vx_q - 8'(hund * 8'd100));
    tens_prod = 15'({8'd0, rem} * 15'd205);
    tens      = tens_prod[14:11];
    ones      = 4'(rem - 7'(tens * 7'd10));
    case (cnt[1:0])
      2'd0:    digit = {6'd0, hund};
      2'd1:    digit = {4'd0, tens};
      default: digit = {4'd0, ones};
    endcase
  end

  // Register file write produced by an executed instruction.
  logic       ex_rwe, ex_flag_en, ex_flag, ex_valid8;
  logic [7:0] ex_rdata;
  logic [8:0] sum9;

  always_comb begin
    ex_rwe     = 1'b0;
    ex_rdata   = 8'd0;
    ex_flag_en = 1'b0;
    ex_flag    = 1'b0;
    ex_valid8  = 1'b1;
    sum9       = {1'b0, vx_q} + {1'b0, vy};
    case (nib)
      4'h6: begin
        ex_rwe = 1'b1; ex_rdata = kk;
      end
      4'h7: begin
        ex_rwe = 1'b1; ex_rdata = vx_q + kk;
      end
      4'h8: begin
        ex_rwe = 1'b1;
        case (op_q[3:0])
          4'h0: ex_rdata = vy;
          4'h2: ex_rdata = vx_q & vy;
          4'h3: ex_rdata = vx_q ^ vy;
          4'h4: begin
            ex_rdata = sum9[7:0]; ex_flag_en = 1'b1; ex_flag = sum9[8];
          end
          4'h5: begin
            ex_rdata = vx_q - vy; ex_flag_en = 1'b1; ex_flag = (vx_q >= vy);
          end
          4'hE: begin
            ex_rdata = {vx_q[6:0], 1'b0}; ex_flag_en = 1'b1; ex_flag = vx_q[7];
          end
          default: begin
            ex_rwe = 1'b0; ex_valid8 = 1'b0;
          end
        endcase
      end
      4'hC: begin
        ex_rwe = 1'b1; ex_rdata = it.random_byte & kk;
      end
      4'hF: begin
        if (kk == KK_GDT) begin
          ex_rwe = 1'b1; ex_rdata = dt;
        end
      end
      default: ex_rwe = 1'b0;
    endcase
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = it.address;
    mem_wdata = it.data;
    mem_raddr = it.address;
    reg_we    = 1'b0;
    reg_waddr = op_q[11:8];
    reg_wdata = ex_rdata;
    reg_raddr = 4'd0;
    fb_we     = 1'b0;
    fb_waddr  = draw_row[4:0];
    fb_wdata  = fbval ^ sprite_mask;
    fb_raddr  = it.address[7:3];
    stk_we    = 1'b0;
    stk_waddr = sc[SIW-1:0];
    stk_wdata = pc2;
    stk_raddr = SIW'(sc - SCW'(1));
    case (state)
      S_DISP: begin
        mem_we = (it.operation == OP_WRITE);
        if (it.operation == OP_STEP) begin
          mem_raddr = pc;
        end
        if (kdn_store) begin
          reg_we = 1'b1; reg_waddr = wtarget; reg_wdata = {4'd0, it.key};
        end
      end
      S_F1:      mem_raddr = pc + 12'd1;
      S_F2:      reg_raddr = hi_q[3:0];
      S_RY:      reg_raddr = op_q[7:4];
      S_EX: begin
        reg_we = ex_rwe;
        stk_we = (nib == 4'h2) && (sc < SCW'(STACK_DEPTH));
      end
      S_WF: begin
        reg_we = 1'b1; reg_waddr = REG_VF; reg_wdata = {7'd0, flag_q};
      end
      S_DRAW_RD: begin
        mem_raddr = ireg + {8'd0, cnt};
        fb_raddr  = draw_row[4:0];
      end
      S_DRAW_WR: fb_we = 1'b1;
      S_BCD: begin
        mem_we = 1'b1; mem_waddr = ireg + {8'd0, cnt}; mem_wdata = digit;
      end
      S_DUMP_RD: reg_raddr = cnt;
      S_DUMP_WR: begin
        mem_we = 1'b1; mem_waddr = ireg + {8'd0, cnt}; mem_wdata = rval;
      end
      S_LOAD_RD: mem_raddr = ireg + {8'd0, cnt};
      S_LOAD_WR: begin
        reg_we = 1'b1; reg_waddr = cnt; reg_wdata = mem_rdata;
      end
      default: mem_we = 1'b0;
    endcase
  end

  assign in_stall = (state != S_IDLE);
  assign pready   = 1'b1;
  assign prdata   = {20'd0, start_addr};

  logic cfg_we;
  assign cfg_we = psel && penable && pwrite && (paddr == 3'd0);

  always_ff @(posedge clk) begin
    rv_q <= reg_valid[reg_raddr];
    fv_q <= fb_valid[fb_raddr];
    if (rst) begin
      state      <= S_IDLE;
      pc         <= START_RESET;
      start_addr <= START_RESET;
      ireg       <= 12'd0;
      sc         <= '0;
      dt         <= 8'd0;
      keys       <= 16'd0;
      waiting    <= 1'b0;
      wtarget    <= 4'd0;
      halted     <= 1'b0;
      reg_valid  <= 16'd0;
      fb_valid   <= 32'd0;
      out_valid  <= 1'b0;
    end else begin
      if (reg_we) begin
        reg_valid[reg_waddr] <= 1'b1;
      end
      if (fb_we) begin
        fb_valid[fb_waddr] <= 1'b1;
      end
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            it       <= in_item;
            op_q     <= 16'd0;
            rd_q     <= 8'd0;
            status_q <= ST_OK;
            state    <= S_DISP;
          end
        end
        S_DISP: begin
          state <= S_DONE;
          case (it.operation)
            OP_READ: state <= S_MRD;
            OP_STEP: begin
              if (halted) begin
                status_q <= ST_HALT;
              end else if (waiting) begin
                status_q <= ST_WAIT;
              end else begin
                state <= S_F1;
              end
            end
            OP_KDN: begin
              keys[it.key] <= 1'b1;
              if (kdn_store) begin
                waiting <= 1'b0;
                pc      <= pc2;
              end
            end
            OP_KUP:  keys[it.key] <= 1'b0;
            OP_TICK: begin
              if (dt != 8'd0) begin
                dt <= dt - 8'd1;
              end
            end
            OP_DISP: begin
              if (it.address[11:8] == 4'd0) begin
                state <= S_FRD;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_MRD: begin
          rd_q  <= mem_rdata;
          state <= S_DONE;
        end
        S_FRD: begin
          rd_q  <= disp_shift[DISP_W-1 -: 8];
          state <= S_DONE;
        end
        S_F1: begin
          hi_q  <= mem_rdata;
          state <= S_F2;
        end
        S_F2: begin
          op_q  <= {hi_q, mem_rdata};
          state <= S_RY;
        end
        S_RY: begin
          vx_q  <= rval;
          state <= S_EX;
        end
        S_EX: begin
          flag_q <= ex_flag;
          state  <= S_DONE;
          pc     <= pc2;
          case (nib)
            4'h0: begin
              if (op_q == OPW_CLS) begin
                fb_valid <= 32'd0;
              end else if (op_q == OPW_RET) begin
                if (sc == '0) begin
                  status_q <= ST_UNF; halted <= 1'b1; pc <= pc;
                end else begin
                  sc    <= sc - SCW'(1);
                  state <= S_RET;
                end
              end else begin
                status_q <= ST_NIMP; halted <= 1'b1; pc <= pc;
              end
            end
            4'h1: pc <= nnn;
            4'h2: begin
              if (sc >= SCW'(STACK_DEPTH)) begin
                status_q <= ST_OVF; halted <= 1'b1; pc <= pc;
              end else begin
                sc <= sc + SCW'(1);
                pc <= nnn;
              end
            end
            4'h3: pc <= (vx_q == kk) ? pc4 : pc2;
            4'h4: pc <= (vx_q != kk) ? pc4 : pc2;
            4'h6, 4'h7, 4'hC: pc <= pc2;
            4'h8: begin
              if (!ex_valid8) begin
                status_q <= ST_NIMP; halted <= 1'b1; pc <= pc;
              end else if (ex_flag_en) begin
                state <= S_WF;
              end
            end
            4'hA: ireg <= nnn;
            4'hD: begin
              x0_q  <= vx_q[5:0];
              y0_q  <= vy[4:0];
              cnt   <= 4'd0;
              hit_q <= 1'b0;
              state <= S_DRAW_RD;
            end
            4'hE: begin
              if (kk == KK_SKP) begin
                pc <= key_hit ? pc4 : pc2;
              end else if (kk == KK_SKNP) begin
                pc <= key_hit ? pc2 : pc4;
              end else begin
                status_q <= ST_NIMP; halted <= 1'b1; pc <= pc;
              end
            end
            4'hF: begin
              cnt <= 4'd0;
              case (kk)
                KK_GDT, KK_SST: pc <= pc2;
                KK_WKEY: begin
                  status_q <= ST_WAIT;
                  waiting  <= 1'b1;
                  wtarget  <= op_q[11:8];
                  pc       <= pc;
                end
                KK_SDT:  dt <= vx_q;
                KK_FONT: ireg <= 12'({4'd0, vx_q} * 12'd5);
                KK_BCD:  state <= S_BCD;
                KK_DUMP: state <= S_DUMP_RD;
                KK_LOAD: state <= S_LOAD_RD;
                KK_ADDI: ireg <= ireg + {4'd0, vx_q};
                default: begin
                  status_q <= ST_NIMP; halted <= 1'b1; pc <= pc;
                end
              endcase
            end
            default: begin
              status_q <= ST_NIMP; halted <= 1'b1; pc <= pc;
            end
          endcase
        end
        S_WF:  state <= S_DONE;
        S_RET: begin
          pc    <= stk_rdata;
          state <= S_DONE;
        end
        S_DRAW_RD: begin
          if ((cnt == op_q[3:0]) || draw_row[5]) begin
            flag_q <= hit_q;
            state  <= S_WF;
          end else begin
            state <= S_DRAW_WR;
          end
        end
        S_DRAW_WR: begin
          hit_q <= hit_q | (|(fbval & sprite_mask));
          cnt   <= cnt + 4'd1;
          state <= S_DRAW_RD;
        end
        S_BCD: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd2) begin
            state <= S_DONE;
          end
        end
        S_DUMP_RD: state <= S_DUMP_WR;
        S_DUMP_WR: begin
          cnt   <= cnt + 4'd1;
          state <= (cnt == op_q[11:8]) ? S_DONE : S_DUMP_RD;
        end
        S_LOAD_RD: state <= S_LOAD_WR;
        S_LOAD_WR: begin
          cnt   <= cnt + 4'd1;
          state <= (cnt == op_q[11:8]) ? S_DONE : S_LOAD_RD;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid                <= 1'b1;
            out_item.pc              <= pc;
            out_item.read_data       <= rd_q;
            out_item.executed_opcode <= op_q;
            if (it.operation == OP_STEP) begin
              out_item.status <= status_q;
            end else if (halted) begin
              out_item.status <= ST_HALT;
            end else if (waiting) begin
              out_item.status <= ST_WAIT;
            end else begin
              out_item.status <= ST_OK;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we) begin
        start_addr <= pwdata[11:0];
        pc         <= pwdata[11:0];
      end
    end
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sc <= SCW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_no_fetch_when_stopped: assert property (@(posedge clk) disable iff (rst)
    (state == S_F1) |-> (!halted && !waiting))
    else $error("fetch while halted or waiting");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> (state == S_DISP))
    else $error("accepted item not dispatched");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(halted) && !$past(rst) |-> halted)
    else $error("halt cleared without reset");

endmodule

/* sim/chip8_instruction_core_unit_tb.sv */
`timescale 1ns / 1ps

module chip8_instruction_core_unit_tb;
  import c8_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    in_item_t  it;
    logic      typed;
    out_item_t ex;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  chip8_instruction_core_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the core.
  logic [7:0]  sh_mem [MEM_BYTES];
  bit          sh_mem_ok [MEM_BYTES];
  logic [7:0]  sh_v [16];
  logic [11:0] sh_i;
  logic [11:0] sh_pc;
  logic [11:0] sh_stack [16];
  int          sh_sp;
  logic [7:0]  sh_dt;
  logic [15:0] sh_keys;
  bit          sh_wait;
  logic [3:0]  sh_wtgt;
  bit          sh_halt;
  logic [63:0] sh_fb [DISP_H];

  out_item_t pending_results[$];
  int        err_cnt = 0;
  int        item_cnt = 0;
  int        cyc = 0;
  bit        no_idle = 0;
  bit        hold_req = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("chip8_instruction_core_unit_tb: done, errors");
      $finish;
    end
  end

  function automatic void mem_put(logic [11:0] a, logic [7:0] d);
    sh_mem[a] = d;
    sh_mem_ok[a] = 1;
  endfunction

  function automatic logic [2:0] idle_state();
    if (sh_halt) return ST_HALT;
    if (sh_wait) return ST_WAIT;
    return ST_OK;
  endfunction

  function automatic out_item_t core_predict(in_item_t it);
    out_item_t   o;
    logic [15:0] w;
    logic [11:0] nx;
    logic [2:0]  st;
    logic [3:0]  x, y;
    logic [7:0]  vx, vy, kk, bits;
    logic [8:0]  sum;
    logic [5:0]  x0;
    logic [4:0]  y0;
    logic        hit;
    int          pos;
    o = '0;
    st = ST_OK;
    case (it.operation)
      OP_WRITE: mem_put(it.address, it.data);
      OP_READ: o.read_data = sh_mem[it.address];
      OP_STEP: begin
        if (sh_halt) st = ST_HALT;
        else if (sh_wait) st = ST_WAIT;
        else begin
          w = {sh_mem[sh_pc], sh_mem[sh_pc + 12'd1]};
          o.executed_opcode = w;
          x = w[11:8];
          y = w[7:4];
          kk = w[7:0];
          vx = sh_v[x];
          vy = sh_v[y];
          nx = sh_pc + 12'd2;
          case (w[15:12])
            4'h0: begin
              if (w == OPW_CLS) begin
                for (int r = 0; r < DISP_H; r++) sh_fb[r] = '0;
              end else if (w == OPW_RET) begin
                if (sh_sp == 0) st = ST_UNF;
                else begin
                  sh_sp--;
                  nx = sh_stack[sh_sp];
                end
              end else st = ST_NIMP;
            end
            4'h1: nx = w[11:0];
            4'h2: begin
              if (sh_sp >= STACK_DEPTH) st = ST_OVF;
              else begin
                sh_stack[sh_sp] = nx;
                sh_sp++;
                nx = w[11:0];
              end
            end
            4'h3: if (vx == kk) nx = sh_pc + 12'd4;
            4'h4: if (vx != kk) nx = sh_pc + 12'd4;
            4'h6: sh_v[x] = kk;
            4'h7: sh_v[x] = vx + kk;
            4'h8: begin
              case (w[3:0])
                4'h0: sh_v[x] = vy;
                4'h2: sh_v[x] = vx & vy;
                4'h3: sh_v[x] = vx ^ vy;
                4'h4: begin
                  sum = {1'b0, vx} + {1'b0, vy};
                  sh_v[x] = sum[7:0];
                  sh_v[REG_VF] = {7'd0, sum[8]};
                end
                4'h5: begin
                  sh_v[x] = vx - vy;
                  sh_v[REG_VF] = {7'd0, vx >= vy};
                end
                4'hE: begin
                  sh_v[x] = {vx[6:0], 1'b0};
                  sh_v[REG_VF] = {7'd0, vx[7]};
                end
                default: st = ST_NIMP;
              endcase
            end
            4'hA: sh_i = w[11:0];
            4'hC: sh_v[x] = it.random_byte & kk;
            4'hD: begin
              x0 = vx[5:0];
              y0 = vy[4:0];
              hit = 0;
              for (int r = 0; r < w[3:0]; r++) begin
                if (int'(y0) + r >= DISP_H) break;
                bits = sh_mem[sh_i + 12'(r)];
                for (int c = 0; c < 8; c++) begin
                  if (int'(x0) + c >= DISP_W) break;
                  if (bits[7-c]) begin
                    pos = 63 - (int'(x0) + c);
                    if (sh_fb[int'(y0) + r][pos]) hit = 1;
                    sh_fb[int'(y0) + r][pos] = ~sh_fb[int'(y0) + r][pos];
                  end
                end
              end
              sh_v[REG_VF] = {7'd0, hit};
            end
            4'hE: begin
              if (kk == KK_SKP) begin
                if (sh_keys[vx[3:0]]) nx = sh_pc + 12'd4;
              end else if (kk == KK_SKNP) begin
                if (!sh_keys[vx[3:0]]) nx = sh_pc + 12'd4;
              end else st = ST_NIMP;
            end
            4'hF: begin
              case (kk)
                KK_GDT: sh_v[x] = sh_dt;
                KK_WKEY: begin
                  sh_wtgt = x;
                  sh_wait = 1;
                  nx = sh_pc;
                  st = ST_WAIT;
                end
                KK_SDT: sh_dt = vx;
                KK_SST: ;
                KK_FONT: sh_i = 12'(5 * vx);
                KK_BCD: begin
                  mem_put(sh_i, 8'(vx / 100));
                  mem_put(sh_i + 12'd1, 8'((vx / 10) % 10));
                  mem_put(sh_i + 12'd2, 8'(vx % 10));
                end
                KK_DUMP: for (int i = 0; i <= x; i++) mem_put(sh_i + 12'(i), sh_v[i]);
                KK_LOAD: for (int i = 0; i <= x; i++) sh_v[i] = sh_mem[sh_i + 12'(i)];
                KK_ADDI: sh_i = sh_i + {4'd0, vx};
                default: st = ST_NIMP;
              endcase
            end
            default: st = ST_NIMP;
          endcase
          if (st >= ST_NIMP) sh_halt = 1;
          else sh_pc = nx;
        end
      end
      OP_KDN: begin
        sh_keys[it.key] = 1'b1;
        if (sh_wait && !sh_halt) begin
          sh_v[sh_wtgt] = {4'd0, it.key};
          sh_wait = 0;
          sh_pc = sh_pc + 12'd2;
        end
      end
      OP_KUP: sh_keys[it.key] = 1'b0;
      OP_TICK: if (sh_dt != 0) sh_dt = sh_dt - 8'd1;
      OP_DISP: begin
        if (it.address < 12'd256)
          o.read_data = sh_fb[it.address[7:3]][63 - 8 * it.address[2:0] -: 8];
      end
      default: ;
    endcase
    if (it.operation != OP_STEP) st = idle_state();
    o.status = st;
    o.pc = sh_pc;
    return o;
  endfunction

  // Offers one item and waits for its transfer; the expectation is queued on transfer.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t ex);
    int gap;
    out_item_t p;
    gap = no_idle ? 0 : int'($urandom_range(0, 16));
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    p = core_predict(it);
    pending_results.push_back(typed ? ex : p);
    item_cnt++;
  endtask

  task automatic send_op(input logic [2:0] op, input logic [11:0] a, input logic [7:0] d,
                         input logic [3:0] k, input logic [7:0] rb);
    in_item_t it;
    it.operation = op;
    it.address = a;
    it.data = d;
    it.key = k;
    it.random_byte = rb;
    send_item(it, 1'b0, '0);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start(input logic [11:0] val);
    drain();
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'd0;
    pwdata <= {20'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sh_pc = val;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [15:0] pick_word();
    logic [3:0] x, y;
    logic [7:0] kk;
    logic [11:0] nnn;
    x = 4'($urandom);
    y = 4'($urandom);
    kk = 8'($urandom);
    nnn = 12'($urandom);
    case ($urandom_range(0, 25))
      0: return OPW_CLS;
      1: return (sh_sp > 0) ? OPW_RET : OPW_CLS;
      2: return {4'h1, nnn};
      3: return (sh_sp < STACK_DEPTH) ? {4'h2, nnn} : {4'h1, nnn};
      4: return {4'h3, x, $urandom_range(0, 1) ? sh_v[x] : kk};
      5: return {4'h4, x, $urandom_range(0, 1) ? sh_v[x] : kk};
      6, 23: return {4'h6, x, kk};
      7: return {4'h7, x, kk};
      8, 24, 25: begin
        case ($urandom_range(0, 5))
          0: return {4'h8, x, y, 4'h0};
          1: return {4'h8, x, y, 4'h2};
          2: return {4'h8, x, y, 4'h3};
          3: return {4'h8, x, y, 4'h4};
          4: return {4'h8, x, y, 4'h5};
          default: return {4'h8, x, y, 4'hE};
        endcase
      end
      9: return {4'hA, nnn};
      10: return {4'hC, x, kk};
      11: return {4'hD, x, y, kk[3:0]};
      12: return {4'hE, x, KK_SKP};
      13: return {4'hE, x, KK_SKNP};
      14: return {4'hF, x, KK_GDT};
      15: return {4'hF, x, KK_WKEY};
      16: return {4'hF, x, KK_SDT};
      17: return {4'hF, x, KK_SST};
      18: return {4'hF, x, KK_FONT};
      19: return {4'hF, x, KK_BCD};
      20: return {4'hF, x, KK_DUMP};
      21: return {4'hF, x, KK_LOAD};
      default: return {4'hF, x, KK_ADDI};
    endcase
  endfunction

  // Places a word at the program counter, fills any unwritten bytes it will read, then steps.
  task automatic run_word(input logic [15:0] w);
    int n;
    logic [11:0] a;
    n = 0;
    if (w[15:12] == 4'hD) n = int'(w[3:0]);
    if (w[15:12] == 4'hF && w[7:0] == KK_LOAD) n = int'(w[11:8]) + 1;
    for (int r = 0; r < n; r++) begin
      a = sh_i + 12'(r);
      if (!sh_mem_ok[a]) send_op(OP_WRITE, a, 8'($urandom), 4'($urandom), 8'($urandom));
    end
    send_op(OP_WRITE, sh_pc, w[15:8], 4'($urandom), 8'($urandom));
    send_op(OP_WRITE, sh_pc + 12'd1, w[7:0], 4'($urandom), 8'($urandom));
    send_op(OP_STEP, 12'($urandom), 8'($urandom), 4'($urandom), 8'($urandom));
  endtask

  task automatic random_item();
    logic [11:0] a;
    int sel;
    sel = int'($urandom_range(0, 99));
    a = 12'($urandom);
    if (sel < 55) run_word(pick_word());
    else if (sel < 65) send_op(OP_WRITE, a, 8'($urandom), 4'($urandom), 8'($urandom));
    else if (sel < 72) begin
      if (!sh_mem_ok[a]) send_op(OP_WRITE, a, 8'($urandom), 4'($urandom), 8'($urandom));
      send_op(OP_READ, a, 8'($urandom), 4'($urandom), 8'($urandom));
    end else if (sel < 80) send_op(OP_KDN, a, 8'($urandom), 4'($urandom), 8'($urandom));
    else if (sel < 85) send_op(OP_KUP, a, 8'($urandom), 4'($urandom), 8'($urandom));
    else if (sel < 90) send_op(OP_TICK, a, 8'($urandom), 4'($urandom), 8'($urandom));
    else if (sel < 98) send_op(OP_DISP, $urandom_range(0, 3) ? {4'd0, a[7:0]} : a,
                               8'($urandom), 4'($urandom), 8'($urandom));
    else send_op(3'd7, a, 8'($urandom), 4'($urandom), 8'($urandom));
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t ex;
    if (pending_results.size() == 0) begin
      $error("result transfer with nothing expected: %h", got);
      err_cnt++;
    end else begin
      ex = pending_results.pop_front();
      if (got.status !== ex.status) begin
        $error("status expected %0d actual %0d", ex.status, got.status);
        err_cnt++;
      end
      if (got.pc !== ex.pc) begin
        $error("pc expected %h actual %h", ex.pc, got.pc);
        err_cnt++;
      end
      if (got.read_data !== ex.read_data) begin
        $error("read_data expected %h actual %h", ex.read_data, got.read_data);
        err_cnt++;
      end
      if (got.executed_opcode !== ex.executed_opcode) begin
        $error("executed_opcode expected %h actual %h", ex.executed_opcode,
               got.executed_opcode);
        err_cnt++;
      end
    end
  endtask

  // Result side: random stall before each transfer, with one long hold-off on request.
  initial begin
    int g;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        g = 400;
        hold_req = 0;
      end else g = no_idle ? 0 : int'($urandom_range(0, 16));
      if (g > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (g - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      check_result(out_item);
    end
  end

  dir_row_t dir_tab [25];

  initial begin
    logic [11:0] starts [4];
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    for (int i = 0; i < MEM_BYTES; i++) begin
      sh_mem[i] = '0;
      sh_mem_ok[i] = 0;
    end
    for (int i = 0; i < 16; i++) begin
      sh_v[i] = '0;
      sh_stack[i] = '0;
    end
    for (int i = 0; i < DISP_H; i++) sh_fb[i] = '0;
    sh_i = '0;
    sh_pc = START_RESET;
    sh_sp = 0;
    sh_dt = '0;
    sh_keys = '0;
    sh_wait = 0;
    sh_wtgt = '0;
    sh_halt = 0;

    dir_tab[0]  = {{OP_DISP, 12'h000, 8'h00, 4'h0, 8'h00}, 1'b1, {ST_OK, 12'h200, 8'h00, 16'h0}};
    dir_tab[1]  = {{OP_DISP, 12'hFFF, 8'hFF, 4'hF, 8'hFF}, 1'b1, {ST_OK, 12'h200, 8'h00, 16'h0}};
    dir_tab[2]  = {{OP_KDN, 12'h000, 8'h00, 4'hF, 8'h00}, 1'b1, {ST_OK, 12'h200, 8'h00, 16'h0}};
    dir_tab[3]  = {{OP_KUP, 12'h000, 8'h00, 4'hF, 8'h00}, 1'b1, {ST_OK, 12'h200, 8'h00, 16'h0}};
    dir_tab[4]  = {{OP_TICK, 12'h000, 8'h00, 4'h0, 8'h00}, 1'b1, {ST_OK, 12'h200, 8'h00, 16'h0}};
    dir_tab[5]  = {{OP_WRITE, 12'h200, 8'h6A, 4'h0, 8'h00}, 1'b0, out_item_t'('0)};
    dir_tab[6]  = {{OP_WRITE, 12'h201, 8'hFF, 4'h0, 8'h00}, 1'b0, out_item_t'('0)};
    dir_tab[7]  = {{OP_STEP, 12'h000, 8'h00, 4'h0, 8'hFF}, 1'b1, {ST_OK, 12'h202, 8'h00, 16'h6AFF}};
    dir_tab[8]  = {{OP_WRITE, 12'h202, 8'h8A, 4'h0, 8'h00}, 1'b0, out_item_t'('0)};
    dir_tab[9]  = {{OP_WRITE, 12'h203, 8'hAE, 4'h0, 8'h00}, 1'b0, out_item_t'('0)};
    dir_tab[10] = {{OP_STEP, 12'h000, 8'h00, 4'h0, 8'h00}, 1'b0, out_item_t'('0)};
    dir_tab[11] = {{OP_WRITE, 12'h204, 8'hF0, 4'h0, 8'h00}, 1'b0, out_item_t'('0)};
    dir_tab[12] = {{OP_WRITE, 12'h205, 8'h0A, 4'h0, 8'h00}, 1'b0, out_item_t'('0)};
    dir_tab[13] = {{OP_STEP, 12'h000, 8'h00, 4'h0, 8'h00}, 1'b1, {ST_WAIT, 12'h204, 8'h00, 16'hF00A}};
    dir_tab[14] = {{OP_STEP, 12'h000, 8'h00, 4'h0, 8'h00}, 1'b1, {ST_WAIT, 12'h204, 8'h00, 16'h0}};
    dir_tab[15] = {{OP_KDN, 12'h000, 8'h00, 4'h7, 8'h00}, 1'b1, {ST_OK, 12'h206, 8'h00, 16'h0}};
    dir_tab[16] = {{OP_WRITE, 12'h000, 8'hFF, 4'h0, 8'h00}, 1'b0, out_item_t'('0)};
    dir_tab[17] = {{OP_WRITE, 12'h206, 8'hD0, 4'h0, 8'h00}, 1'b0, out_item_t'('0)};
    dir_tab[18] = {{OP_WRITE, 12'h207, 8'h01, 4'h0, 8'h00}, 1'b0, out_item_t'('0)};
    dir_tab[19] = {{OP_STEP, 12'h000, 8'h00, 4'h0, 8'h00}, 1'b0, out_item_t'('0)};
    dir_tab[20] = {{OP_DISP, 12'h000, 8'h00, 4'h0, 8'h00}, 1'b0, out_item_t'('0)};
    dir_tab[21] = {{OP_DISP, 12'h001, 8'h00, 4'h0, 8'h00}, 1'b0, out_item_t'('0)};
    dir_tab[22] = {{OP_READ, 12'h000, 8'h00, 4'h0, 8'h00}, 1'b1, {ST_OK, 12'h208, 8'hFF, 16'h0}};
    dir_tab[23] = {{OP_WRITE, 12'hFFF, 8'h00, 4'h0, 8'h00}, 1'b0, out_item_t'('0)};
    dir_tab[24] = {{OP_READ, 12'hFFF, 8'h00, 4'h0, 8'h00}, 1'b1, {ST_OK, 12'h208, 8'h00, 16'h0}};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].ex);

    // Extremes of the start address first, then random ones, then the reset value.
    starts[0] = 12'hFFF;
    starts[1] = 12'h000;
    starts[2] = 12'($urandom);
    starts[3] = 12'($urandom);
    for (int ph = 0; ph < 6; ph++) begin
      write_start(ph < 4 ? starts[ph] : 12'(START_RESET));
      no_idle = (ph == 3);
      if (ph == 2) hold_req = 1;
      for (int k = 0; k < 60; k++) random_item();
      // In phase 1 the sender pauses until every result is back, then resumes the phase.
      if (ph == 1) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
      end
      while (item_cnt < 25 + (ph + 1) * 200) random_item();
    end
    no_idle = 0;

    // A pending key wait would keep every step from faulting, so release it first.
    if (sh_wait) send_op(OP_KDN, '0, '0, 4'($urandom), '0);

    // Only one halt is possible per reset; the seed picks which fault ends the run.
    case ($urandom_range(0, 2))
      0: begin
        case ($urandom_range(0, 3))
          0: run_word({4'h5, 12'($urandom)});
          1: run_word({4'h9, 12'($urandom)});
          2: run_word({4'hB, 12'($urandom)});
          default: run_word({4'h8, 8'($urandom), 4'h1});
        endcase
      end
      1: while (!sh_halt) run_word({4'h2, 12'($urandom)});
      default: while (!sh_halt) begin
        if (sh_wait) send_op(OP_KDN, '0, '0, 4'($urandom), '0);
        else run_word(OPW_RET);
      end
    endcase
    run_word(pick_word());
    send_op(OP_KDN, '0, '0, 4'($urandom), '0);
    send_op(OP_TICK, '0, '0, '0, '0);
    send_op(OP_DISP, 12'($urandom_range(0, 255)), '0, '0, '0);

    drain();
    if (pending_results.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("chip8_instruction_core_unit_tb: done, clean");
    end else begin
      $display("chip8_instruction_core_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/c8_pkg.sv
hdl/c8_ram.sv
hdl/chip8_instruction_core_unit.sv
sim/chip8_instruction_core_unit_tb.sv
